// File: rtl/dfs_maze_carver_assert.svh
// Assertion macros used by the checker of the maze carver.
`ifndef DFS_MAZE_CARVER_ASSERT_SVH
`define DFS_MAZE_CARVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCARV_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("maze carver check failed");

// Consequent must hold in the cycle after the antecedent.
`define MCARV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("maze carver check failed");

`endif

// File: rtl/mcarv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcarv_pkg;

    // Field and bus widths.
    localparam int KIND_W   = 2;
    localparam int COORD_W  = 5;
    localparam int RND_W    = 15;
    localparam int ACT_W    = 3;
    localparam int WALLS_W  = 4;
    localparam int SIZE_W   = 6;
    localparam int CNT_W    = 2 * SIZE_W;
    localparam int SDATA_W  = 32;
    localparam int MDATA_W  = 16;
    localparam int CELL_DW  = WALLS_W + 1;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Result actions.
    localparam logic [ACT_W-1:0] ACT_STARTED     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CARVED      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BACKTRACKED = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DONE        = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WALLS       = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BAD         = 3'd5;

    // Neighbor directions, in candidate order. The opposite direction is dir ^ 1.
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [WALLS_W-1:0] ALL_WALLS = 4'hF;

    // Outcome of the neighbor choice.
    typedef struct packed {
        logic       found;
        logic [1:0] dir;
    } pick_t;

    // Wall bit that faces a direction: bit0 left, bit1 right, bit2 top, bit3 bottom.
    function automatic logic [WALLS_W-1:0] wall_bit(input logic [1:0] dir);
        logic [WALLS_W-1:0] m;
        m = '0;
        m[dir] = 1'b1;
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mcarv_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mcarv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port with registered data.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/mcarv_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module mcarv_pick (
    input  wire logic [3:0]                  cand,
    input  wire logic [mcarv_pkg::RND_W-1:0] rnd,
    output mcarv_pkg::pick_t                 pick
);

    logic [2:0] n;
    logic [1:0] k;
    logic [2:0] cnt;
    logic [1:0] rnd_mod3;

    // Remainder by three: base-4 digits sum to the same residue, then fold twice.
    function automatic logic [1:0] mod3(input logic [mcarv_pkg::RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8])
          + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[14]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    assign rnd_mod3 = mod3(rnd);

    // Count candidates and reduce the random word modulo that count.
    always_comb begin
        n = '0;
        for (int d = 0; d < 4; d++) begin
            n = n + 3'(cand[d]);
        end
        case (n)
            3'd2: k = {1'b0, rnd[0]};
            3'd3: k = rnd_mod3;
            3'd4: k = rnd[1:0];
            default: k = '0;
        endcase
    end

    // Select the k-th candidate in left, right, up, down order.
    always_comb begin
        cnt  = '0;
        pick = '0;
        for (int d = 0; d < 4; d++) begin
            if (cand[d]) begin
                if (!pick.found && cnt == {1'b0, k}) begin
                    pick.found = 1'b1;
                    pick.dir   = 2'(d);
                end
                cnt = cnt + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/dfs_maze_carver.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word contents
// s_axis    in         tuser: kind; tdata: cell_x, cell_y, random_value
// m_axis    out        tuser: action; tdata: pos_x, pos_y, walls, finished
// cfg       in         cfg_index 0 grid_width, 1 grid_height
//
// One item is worked at a time; the cell map and the stack are synchronous RAMs
// with one read and one write port, and the neighbor probe reads one per cycle.
// Step: probe the neighbors (ST_NB), pick one (ST_PICK), then carve (ST_CARVE)
// or pop the stack (ST_POP1, ST_POP2). Read: ST_RD. A refused word, a step when
// done and a read before the first start go to ST_EMIT. Start: map sweep (ST_CLEAR).
// Reset is synchronous and clears control state only; the map is swept by each valid
// start. A held result in the output register does not block acceptance of the
// next word; a result that cannot move on holds the block until the register frees.

module dfs_maze_carver #(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port.
    input  wire logic                                cfg_we,
    input  wire logic [mcarv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mcarv_pkg::SIZE_W-1:0]        cfg_wdata,
    // Input words.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mcarv_pkg::SDATA_W-1:0]       s_tdata,  // cell_x, cell_y, random_value
    input  wire logic [mcarv_pkg::KIND_W-1:0]        s_tuser,  // kind
    // Result words.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [mcarv_pkg::MDATA_W-1:0]       m_tdata,  // pos_x, pos_y, walls, finished
    output logic      [mcarv_pkg::ACT_W-1:0]         m_tuser   // action
);

    localparam int XW         = $clog2(MAX_COLUMNS);
    localparam int YW         = $clog2(MAX_ROWS);
    localparam int CW         = XW + YW;
    localparam int CELL_DEPTH = 1 << CW;
    localparam int DW         = CW + 1;

    localparam int SIZE_W  = mcarv_pkg::SIZE_W;
    localparam int CNT_W   = mcarv_pkg::CNT_W;
    localparam int COORD_W = mcarv_pkg::COORD_W;
    localparam int WALLS_W = mcarv_pkg::WALLS_W;
    localparam int CELL_DW = mcarv_pkg::CELL_DW;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_NB    = 4'd2;
    localparam logic [3:0] ST_PICK  = 4'd3;
    localparam logic [3:0] ST_CARVE = 4'd4;
    localparam logic [3:0] ST_POP1  = 4'd5;
    localparam logic [3:0] ST_POP2  = 4'd6;
    localparam logic [3:0] ST_RD    = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    // Control state.
    logic [3:0]          state_reg, state_next;
    logic [SIZE_W-1:0]   grid_width_reg, grid_width_next;
    logic [SIZE_W-1:0]   grid_height_reg, grid_height_next;
    logic [SIZE_W-1:0]   act_w_reg, act_w_next;
    logic [SIZE_W-1:0]   act_h_reg, act_h_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    visited_total_reg, visited_total_next;
    logic                started_reg, started_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [XW-1:0]       cur_x_reg, cur_x_next;
    logic [YW-1:0]       cur_y_reg, cur_y_next;
    logic [2:0]          nb_cnt_reg, nb_cnt_next;
    logic [CW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Working and result payload.
    logic [WALLS_W-1:0]              cur_walls_reg, cur_walls_next;
    logic [mcarv_pkg::RND_W-1:0]     rnd_reg, rnd_next;
    logic [3:0]                      vis_reg, vis_next;
    logic [COORD_W-1:0]              res_x_reg, res_x_next;
    logic [COORD_W-1:0]              res_y_reg, res_y_next;
    logic [mcarv_pkg::ACT_W-1:0]     res_act_reg, res_act_next;
    logic [WALLS_W-1:0]              res_walls_reg, res_walls_next;
    logic [mcarv_pkg::MDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [mcarv_pkg::ACT_W-1:0]     m_tuser_reg, m_tuser_next;

    // Memory ports.
    logic               map_we;
    logic [CW-1:0]      map_waddr, map_raddr;
    logic [CELL_DW-1:0] map_wdata, map_rdata;
    logic               stk_we;
    logic [CW-1:0]      stk_waddr, stk_raddr;
    logic [CW-1:0]      stk_wdata, stk_rdata;

    // Input word fields.
    logic                          acc;
    logic [mcarv_pkg::KIND_W-1:0]  in_kind;
    logic [COORD_W-1:0]            in_x, in_y;
    logic [mcarv_pkg::RND_W-1:0]   in_rnd;
    logic [CW-1:0]                 in_addr;

    logic [SIZE_W-1:0]  clamp_w, clamp_h;
    logic               start_ok, read_ok, finished;
    logic [CW-1:0]      cur_addr;
    logic [3:0]         in_grid, cand;
    logic [CW-1:0]      nb_addr [4];
    logic [1:0]         nb_idx;
    logic [XW-1:0]      new_x;
    logic [YW-1:0]      new_y;
    mcarv_pkg::pick_t   pick;

    assign acc     = s_tvalid && s_tready;
    assign in_kind = s_tuser;
    assign in_x    = s_tdata[4:0];
    assign in_y    = s_tdata[9:5];
    assign in_rnd  = s_tdata[24:10];
    assign in_addr = {YW'(in_y), XW'(in_x)};

    // Register sizes limited to one cell at least and the grid maximum at most.
    always_comb begin
        if (grid_width_reg == '0) begin
            clamp_w = SIZE_W'(1);
        end else if (int'(grid_width_reg) > MAX_COLUMNS) begin
            clamp_w = SIZE_W'(MAX_COLUMNS);
        end else begin
            clamp_w = grid_width_reg;
        end
        if (grid_height_reg == '0) begin
            clamp_h = SIZE_W'(1);
        end else if (int'(grid_height_reg) > MAX_ROWS) begin
            clamp_h = SIZE_W'(MAX_ROWS);
        end else begin
            clamp_h = grid_height_reg;
        end
    end

    assign start_ok = ({1'b0, in_x} < clamp_w) && ({1'b0, in_y} < clamp_h);
    assign read_ok  = ({1'b0, in_x} < act_w_reg) && ({1'b0, in_y} < act_h_reg);
    assign finished = started_reg && (visited_total_reg >= total_reg);

    // Neighbors of the current cell and whether they lie inside the grid.
    assign cur_addr = {cur_y_reg, cur_x_reg};
    assign in_grid[mcarv_pkg::DIR_LEFT]  = (cur_x_reg != '0);
    assign in_grid[mcarv_pkg::DIR_RIGHT] = (9'(cur_x_reg) + 9'd1) < 9'(act_w_reg);
    assign in_grid[mcarv_pkg::DIR_UP]    = (cur_y_reg != '0);
    assign in_grid[mcarv_pkg::DIR_DOWN]  = (9'(cur_y_reg) + 9'd1) < 9'(act_h_reg);
    assign nb_addr[mcarv_pkg::DIR_LEFT]  = {cur_y_reg, cur_x_reg - XW'(1)};
    assign nb_addr[mcarv_pkg::DIR_RIGHT] = {cur_y_reg, cur_x_reg + XW'(1)};
    assign nb_addr[mcarv_pkg::DIR_UP]    = {cur_y_reg - YW'(1), cur_x_reg};
    assign nb_addr[mcarv_pkg::DIR_DOWN]  = {cur_y_reg + YW'(1), cur_x_reg};
    assign cand   = in_grid & ~vis_reg;
    assign nb_idx = 2'(nb_cnt_reg - 3'd1);

    mcarv_pick u_pick (
        .cand (cand),
        .rnd  (rnd_reg),
        .pick (pick)
    );

    // Coordinates of the chosen neighbor.
    always_comb begin
        new_x = cur_x_reg;
        new_y = cur_y_reg;
        case (pick.dir)
            mcarv_pkg::DIR_LEFT:  new_x = cur_x_reg - XW'(1);
            mcarv_pkg::DIR_RIGHT: new_x = cur_x_reg + XW'(1);
            mcarv_pkg::DIR_UP:    new_y = cur_y_reg - YW'(1);
            mcarv_pkg::DIR_DOWN:  new_y = cur_y_reg + YW'(1);
            default: new_x = cur_x_reg;
        endcase
    end

    // Sequencer: decode a word, run its memory accesses, then hand the result on.
    always_comb begin
        state_next         = state_reg;
        grid_width_next    = grid_width_reg;
        grid_height_next   = grid_height_reg;
        act_w_next         = act_w_reg;
        act_h_next         = act_h_reg;
        total_next         = total_reg;
        visited_total_next = visited_total_reg;
        started_next       = started_reg;
        depth_next         = depth_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        nb_cnt_next        = nb_cnt_reg;
        clr_cnt_next       = clr_cnt_reg;
        m_tvalid_next      = m_tvalid_reg;
        cur_walls_next     = cur_walls_reg;
        rnd_next           = rnd_reg;
        vis_next           = vis_reg;
        res_x_next         = res_x_reg;
        res_y_next         = res_y_reg;
        res_act_next       = res_act_reg;
        res_walls_next     = res_walls_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;
        map_we             = 1'b0;
        map_waddr          = cur_addr;
        map_wdata          = {1'b1, cur_walls_reg};
        map_raddr          = in_addr;
        stk_we             = 1'b0;
        stk_waddr          = depth_reg[CW-1:0];
        stk_wdata          = cur_addr;
        stk_raddr          = CW'(depth_reg - DW'(1));

        // The output register drains independently of the sequencer.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_we) begin
            if (cfg_index == mcarv_pkg::REG_GRID_WIDTH) begin
                grid_width_next = cfg_wdata;
            end else if (cfg_index == mcarv_pkg::REG_GRID_HEIGHT) begin
                grid_height_next = cfg_wdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    rnd_next       = in_rnd;
                    res_x_next     = '0;
                    res_y_next     = '0;
                    res_act_next   = mcarv_pkg::ACT_BAD;
                    res_walls_next = '0;
                    state_next     = ST_EMIT;
                    case (in_kind)
                        mcarv_pkg::KIND_START: begin
                            res_x_next = in_x;
                            res_y_next = in_y;
                            if (start_ok) begin
                                act_w_next         = clamp_w;
                                act_h_next         = clamp_h;
                                total_next         = CNT_W'(clamp_w) * CNT_W'(clamp_h);
                                started_next       = 1'b1;
                                visited_total_next = CNT_W'(1);
                                depth_next         = DW'(1);
                                cur_x_next         = XW'(in_x);
                                cur_y_next         = YW'(in_y);
                                cur_walls_next     = mcarv_pkg::ALL_WALLS;
                                stk_we             = 1'b1;
                                stk_waddr          = '0;
                                stk_wdata          = in_addr;
                                clr_cnt_next       = '0;
                                res_act_next       = mcarv_pkg::ACT_STARTED;
                                res_walls_next     = mcarv_pkg::ALL_WALLS;
                                state_next         = ST_CLEAR;
                            end
                        end
                        mcarv_pkg::KIND_STEP: begin
                            if (started_reg) begin
                                res_x_next     = COORD_W'(cur_x_reg);
                                res_y_next     = COORD_W'(cur_y_reg);
                                res_act_next   = mcarv_pkg::ACT_DONE;
                                res_walls_next = cur_walls_reg;
                                if (visited_total_reg < total_reg) begin
                                    nb_cnt_next = '0;
                                    state_next  = ST_NB;
                                end
                            end
                        end
                        mcarv_pkg::KIND_READ: begin
                            res_x_next = in_x;
                            res_y_next = in_y;
                            if (read_ok) begin
                                res_act_next = mcarv_pkg::ACT_WALLS;
                                if (started_reg) begin
                                    state_next = ST_RD;
                                end else begin
                                    // The map has not been swept yet, so report all four walls.
                                    res_walls_next = mcarv_pkg::ALL_WALLS;
                                end
                            end
                        end
                        default: begin
                            res_act_next = mcarv_pkg::ACT_BAD;
                        end
                    endcase
                end
            end

            // Rewrite every map entry; the start cell comes out visited.
            ST_CLEAR: begin
                map_we       = 1'b1;
                map_waddr    = clr_cnt_reg;
                map_wdata    = {(clr_cnt_reg == cur_addr), mcarv_pkg::ALL_WALLS};
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(CELL_DEPTH - 1)) begin
                    state_next = ST_EMIT;
                end
            end

            // Probe the four neighbors, one read issued and one captured per cycle.
            ST_NB: begin
                map_raddr = nb_addr[nb_cnt_reg[1:0]];
                if (nb_cnt_reg != '0) begin
                    vis_next[nb_idx] = map_rdata[WALLS_W];
                end
                nb_cnt_next = nb_cnt_reg + 3'd1;
                if (nb_cnt_reg == 3'd4) begin
                    state_next = ST_PICK;
                end
            end

            // Carve toward the chosen neighbor, pop the stack, or report done when it is empty.
            ST_PICK: begin
                if (pick.found) begin
                    map_we             = 1'b1;
                    map_waddr          = cur_addr;
                    map_wdata          = {1'b1, cur_walls_reg & ~mcarv_pkg::wall_bit(pick.dir)};
                    stk_we             = 1'b1;
                    stk_waddr          = depth_reg[CW-1:0];
                    stk_wdata          = {new_y, new_x};
                    depth_next         = depth_reg + DW'(1);
                    visited_total_next = visited_total_reg + CNT_W'(1);
                    cur_x_next         = new_x;
                    cur_y_next         = new_y;
                    cur_walls_next     = mcarv_pkg::ALL_WALLS
                                       & ~mcarv_pkg::wall_bit(pick.dir ^ 2'd1);
                    state_next         = ST_CARVE;
                end else if (depth_reg != '0) begin
                    depth_next = depth_reg - DW'(1);
                    state_next = ST_POP1;
                end else begin
                    state_next = ST_EMIT;
                end
            end

            // The new cell was unvisited, so it held all four walls until now.
            ST_CARVE: begin
                map_we         = 1'b1;
                map_waddr      = cur_addr;
                map_wdata      = {1'b1, cur_walls_reg};
                res_x_next     = COORD_W'(cur_x_reg);
                res_y_next     = COORD_W'(cur_y_reg);
                res_act_next   = mcarv_pkg::ACT_CARVED;
                res_walls_next = cur_walls_reg;
                state_next     = ST_EMIT;
            end

            // Stack top is back; fetch its walls.
            ST_POP1: begin
                map_raddr  = stk_rdata;
                cur_x_next = stk_rdata[XW-1:0];
                cur_y_next = stk_rdata[CW-1:XW];
                state_next = ST_POP2;
            end

            ST_POP2: begin
                cur_walls_next = map_rdata[WALLS_W-1:0];
                res_x_next     = COORD_W'(cur_x_reg);
                res_y_next     = COORD_W'(cur_y_reg);
                res_act_next   = mcarv_pkg::ACT_BACKTRACKED;
                res_walls_next = map_rdata[WALLS_W-1:0];
                state_next     = ST_EMIT;
            end

            ST_RD: begin
                res_walls_next = map_rdata[WALLS_W-1:0];
                state_next     = ST_EMIT;
            end

            // Move the result into the output register once it is free.
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, finished, res_walls_reg, res_y_reg, res_x_reg};
                    m_tuser_next  = res_act_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            grid_width_reg    <= SIZE_W'(16);
            grid_height_reg   <= SIZE_W'(16);
            act_w_reg         <= SIZE_W'(16);
            act_h_reg         <= SIZE_W'(16);
            total_reg         <= CNT_W'(256);
            visited_total_reg <= '0;
            started_reg       <= 1'b0;
            depth_reg         <= '0;
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            nb_cnt_reg        <= '0;
            clr_cnt_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            grid_width_reg    <= grid_width_next;
            grid_height_reg   <= grid_height_next;
            act_w_reg         <= act_w_next;
            act_h_reg         <= act_h_next;
            total_reg         <= total_next;
            visited_total_reg <= visited_total_next;
            started_reg       <= started_next;
            depth_reg         <= depth_next;
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            nb_cnt_reg        <= nb_cnt_next;
            clr_cnt_reg       <= clr_cnt_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_walls_reg <= cur_walls_next;
        rnd_reg       <= rnd_next;
        vis_reg       <= vis_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_act_reg   <= res_act_next;
        res_walls_reg <= res_walls_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    // Cell map: visited bit over four wall bits.
    mcarv_ram #(
        .WIDTH (CELL_DW),
        .DEPTH (CELL_DEPTH)
    ) u_map_ram (
        .clk   (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Backtrack stack of cell addresses.
    mcarv_ram #(
        .WIDTH (CW),
        .DEPTH (CELL_DEPTH)
    ) u_stack_ram (
        .clk   (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: rtl/mcarv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dfs_maze_carver_assert.svh"

module mcarv_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [mcarv_pkg::MDATA_W-1:0]   m_tdata,
    input wire logic [mcarv_pkg::ACT_W-1:0]     m_tuser
);

    logic [mcarv_pkg::WALLS_W-1:0] out_walls;

    assign out_walls = m_tdata[13:10];

    // A stalled result word holds.
    `MCARV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // An accepted word leaves the block busy, so s_tready drops after acceptance.
    `MCARV_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A fresh start reports a cell with all four walls.
    `MCARV_ASSERT_NOW(a_start_walls, aclk, aresetn, m_tvalid && m_tuser == mcarv_pkg::ACT_STARTED, out_walls == mcarv_pkg::ALL_WALLS)

    // A carved cell reports fewer than four walls, having lost the wall toward the cell it came from.
    `MCARV_ASSERT_NOW(a_carve_opened, aclk, aresetn, m_tvalid && m_tuser == mcarv_pkg::ACT_CARVED, out_walls != mcarv_pkg::ALL_WALLS)

    // Refused words report no walls.
    `MCARV_ASSERT_NOW(a_bad_no_walls, aclk, aresetn, m_tvalid && m_tuser == mcarv_pkg::ACT_BAD, out_walls == '0)

endmodule

bind dfs_maze_carver mcarv_checker u_mcarv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
